// ===== rtl/core/cpu16_pkg.sv =====
// Shared types and constants for the cpu16 instruction step block.
`timescale 1ns / 1ps
package cpu16_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned STACK_CW    = $clog2(STACK_DEPTH + 1);

  localparam logic [31:0] ADDR_LIMIT  = 32'h07FF_FFFF;
  localparam logic [31:0] RET_MASK    = 32'h07FF_FFFF;

  typedef enum logic [3:0] {
    OP_WIN   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_AND   = 4'd3,
    OP_OR    = 4'd4,
    OP_NOT   = 4'd5,
    OP_XOR   = 4'd6,
    OP_SHL   = 4'd7,
    OP_SHR   = 4'd8,
    OP_LOAD  = 4'd9,
    OP_STORE = 4'd10,
    OP_JTGT  = 4'd11,
    OP_JUMP  = 4'd12,
    OP_CALL  = 4'd13,
    OP_RET   = 4'd14,
    OP_BAD   = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_INSTR = 3'd1,
    PH_X     = 3'd2,
    PH_Y     = 3'd3,
    PH_LOAD  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_BAD_COND  = 3'd4,
    ST_BAD_OP    = 3'd5,
    ST_STRAY_RET = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_READ  = 2'd1,
    BUS_WRITE = 2'd2
  } bus_op_e;

  typedef enum logic [3:0] {
    CC_NEVER = 4'd0,
    CC_SLT   = 4'd1,
    CC_SEQ   = 4'd2,
    CC_SLE   = 4'd3,
    CC_SGT   = 4'd4,
    CC_SNE   = 4'd5,
    CC_SGE   = 4'd6,
    CC_ALWAYS= 4'd7,
    CC_ULT   = 4'd8,
    CC_UEQ   = 4'd9,
    CC_ULE   = 4'd10,
    CC_UGT   = 4'd11,
    CC_UNE   = 4'd12,
    CC_UGE   = 4'd13,
    CC_BAD0  = 4'd14,
    CC_BAD1  = 4'd15
  } cond_e;

  typedef struct packed {
    logic [15:0] res;
    logic        carry;
    logic        carry_we;
  } alu_out_t;

endpackage

// ===== rtl/core/cpu16_if.sv =====
// Valid/ready channel interfaces for the cpu16 input and result streams.
`timescale 1ns / 1ps
interface cpu16_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        irq;
  logic [15:0] read_data;
  modport source (output valid, action, irq, read_data, input ready);
  modport sink   (input valid, action, irq, read_data, output ready);
endinterface

interface cpu16_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bus_op;
  logic [31:0] bus_address;
  logic [15:0] write_data;
  logic        done_res;
  logic [2:0]  status;
  logic [31:0] program_address;
  modport source (output valid, bus_op, bus_address, write_data, done_res, status,
                  program_address, input ready);
  modport sink   (input valid, bus_op, bus_address, write_data, done_res, status,
                  program_address, output ready);
endinterface

// ===== rtl/core/cpu16_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpu16_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/cpu16_alu.sv =====
// Arithmetic, logic, shift and rotate unit of the cpu16 core.
`timescale 1ns / 1ps
module cpu16_alu import cpu16_pkg::*; (
  input  logic [3:0]  op_i,
  input  logic        m_i,
  input  logic [15:0] x_i,
  input  logic [15:0] y_i,
  input  logic        carry_i,
  output alu_out_t    alu_o
);
  logic [16:0] sum;
  logic [16:0] sub_t;
  logic [31:0] dbl;
  logic [31:0] shl_w;
  logic [3:0]  sh;

  always_comb begin
    sh    = y_i[3:0];
    dbl   = {x_i, x_i};
    shl_w = {16'h0, x_i} << sh;
    sum   = {1'b0, x_i} + {1'b0, y_i};
    sub_t = {1'b0, y_i} + {16'h0, m_i & carry_i};
    alu_o = '0;
    case (opcode_e'(op_i))
      OP_ADD: begin
        alu_o.res      = sum[15:0] + {15'h0, m_i & carry_i};
        alu_o.carry    = sum[16];
        alu_o.carry_we = 1'b1;
      end
      OP_SUB: begin
        // true borrow of x - (y + carry), with carry added only when m is set
        alu_o.res      = x_i - sub_t[15:0];
        alu_o.carry    = {1'b0, x_i} < sub_t;
        alu_o.carry_we = 1'b1;
      end
      OP_AND: alu_o.res = x_i & (m_i ? ~y_i : y_i);
      OP_OR:  alu_o.res = x_i | (m_i ? ~y_i : y_i);
      OP_XOR: alu_o.res = x_i ^ (m_i ? ~y_i : y_i);
      OP_NOT: alu_o.res = ~x_i + {15'h0, m_i};
      OP_SHL: begin
        if (m_i) begin
          alu_o.res = 16'((dbl << sh) >> 16);
        end else begin
          alu_o.res      = shl_w[15:0];
          alu_o.carry    = shl_w[16];
          alu_o.carry_we = 1'b1;
        end
      end
      OP_SHR: begin
        if (m_i) begin
          alu_o.res = 16'(dbl >> sh);
        end else begin
          alu_o.res      = x_i >> sh;
          alu_o.carry    = x_i[0];
          alu_o.carry_we = 1'b1;
        end
      end
      default: alu_o = '0;
    endcase
  end
endmodule

// ===== rtl/core/cpu16_instruction_step_top.sv =====
// Top level of the cpu16 core: sequencing, register file, return stack, result register.
// Usage:
//   in_i carries bus events: action 0 starts the next instruction (irq sampled),
//   action 1 returns a read word for the last read request. out_o carries one
//   result per input transfer: the next bus request, a done flag, status and the
//   program address after the step.
//   The result is registered and appears in the cycle after the input transfer.
//   Throughput: one input transfer per cycle unless the receiver stalls; every
//   step is one pass of decode and ALU logic from state registers to result register.
//   The return stack keeps its top entry in a register and the rest in a RAM
//   whose registered read is primed with the entry below the top, with a
//   bypass for a push immediately followed by a pop.
//   Reset clears all architectural state and the result valid flag, not the result data;
//   the stack RAM needs no clearing since entries are only read after being pushed.
//   When the receiver stalls, the result is held and input is accepted again
//   as soon as the held result is transferred (or in the same cycle).
`timescale 1ns / 1ps
module cpu16_instruction_step_top import cpu16_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cpu16_in_if.sink    in_i,
  cpu16_out_if.source out_o
);
  logic [15:0] regs_q [8];
  logic [15:0] regs_d [8];
  logic [15:0] pc_q, pc_d, pw_q, pw_d;
  logic [10:0] dw_q, dw_d;
  logic [31:0] jt_q, jt_d, va_q, va_d, sr_q, sr_d;
  logic        masked_q, masked_d, active_q, active_d, carry_q, carry_d;
  logic [STACK_CW-1:0] cnt_q, cnt_d;
  logic [31:0] tos_q, tos_d;
  logic        byp_q, byp_d;
  logic [31:0] byp_data_q, byp_data_d;
  phase_e      phase_q, phase_d;
  logic [15:0] il_q, il_d, ox_q, ox_d, oy_q, oy_d;

  logic        out_valid_q;
  logic [1:0]  o_op_q, o_op_d;
  logic [31:0] o_addr_q, o_addr_d, o_pa_q;
  logic [15:0] o_wd_q, o_wd_d;
  logic        o_done_q, o_done_d;
  logic [2:0]  o_st_q, o_st_d;

  logic        acc;
  logic [31:0] prog, pa, nxt, daddr, below, ram_rdata;
  logic [32:0] last_w;
  logic [15:0] ex_ins, ex_x, ex_y, inc_x;
  logic [1:0]  ilen;
  logic        do_exec, ex_m, cond_ok, push;
  logic [3:0]  cc;
  logic [STACK_AW-1:0] ram_waddr, ram_raddr;
  logic [STACK_CW-1:0] raddr_full;
  alu_out_t    alu;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign prog       = {pw_q, pc_q};

  assign ex_ins = (phase_q == PH_INSTR) ? in_i.read_data : il_q;
  assign ex_m   = ex_ins[11];
  assign ex_x   = (phase_q == PH_INSTR) ? regs_q[in_i.read_data[6:4]] :
                  (phase_q == PH_X)     ? in_i.read_data : ox_q;
  assign ex_y   = (phase_q == PH_INSTR) ? regs_q[in_i.read_data[2:0]] :
                  (phase_q == PH_Y)     ? in_i.read_data : oy_q;
  assign ilen   = 2'd1 + {1'b0, ex_ins[7]} + {1'b0, ex_ins[3]};
  assign nxt    = prog + {30'h0, ilen};
  assign daddr  = {5'h0, dw_q, ex_x};
  assign cc     = {ex_m, ex_ins[10:8]};
  // entry just written by a push is not yet visible on the RAM read port
  assign below  = byp_q ? byp_data_q : ram_rdata;

  cpu16_alu u_alu (
    .op_i    (ex_ins[15:12]),
    .m_i     (ex_m),
    .x_i     (ex_x),
    .y_i     (ex_y),
    .carry_i (carry_q),
    .alu_o   (alu)
  );

  always_comb begin
    case (cond_e'(cc))
      CC_SLT:    cond_ok = $signed(ex_x) <  $signed(ex_y);
      CC_SEQ,
      CC_UEQ:    cond_ok = ex_x == ex_y;
      CC_SLE:    cond_ok = $signed(ex_x) <= $signed(ex_y);
      CC_SGT:    cond_ok = $signed(ex_x) >  $signed(ex_y);
      CC_SNE,
      CC_UNE:    cond_ok = ex_x != ex_y;
      CC_SGE:    cond_ok = $signed(ex_x) >= $signed(ex_y);
      CC_ALWAYS: cond_ok = 1'b1;
      CC_ULT:    cond_ok = ex_x <  ex_y;
      CC_ULE:    cond_ok = ex_x <= ex_y;
      CC_UGT:    cond_ok = ex_x >  ex_y;
      CC_UGE:    cond_ok = ex_x >= ex_y;
      default:   cond_ok = 1'b0;
    endcase
  end

  // Sequencing and execution for one accepted item
  always_comb begin
    regs_d   = regs_q;
    pc_d     = pc_q;
    pw_d     = pw_q;
    dw_d     = dw_q;
    jt_d     = jt_q;
    va_d     = va_q;
    sr_d     = sr_q;
    masked_d = masked_q;
    active_d = active_q;
    carry_d  = carry_q;
    cnt_d    = cnt_q;
    tos_d    = tos_q;
    phase_d  = phase_q;
    il_d     = il_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    o_op_d   = BUS_NONE;
    o_addr_d = '0;
    o_wd_d   = '0;
    o_done_d = 1'b0;
    o_st_d   = ST_OK;
    do_exec  = 1'b0;
    push     = 1'b0;
    pa       = prog;
    last_w   = {1'b0, prog} + {31'h0, ilen} - 33'd1;
    inc_x    = ox_q + 16'd1;

    if (acc) begin
      if (!in_i.action) begin
        if (in_i.irq && !masked_q) begin
          sr_d     = prog;
          active_d = 1'b1;
          masked_d = 1'b1;
          pa       = va_q;
          pc_d     = va_q[15:0];
          pw_d     = va_q[31:16];
        end
        if (pa > ADDR_LIMIT) begin
          phase_d  = PH_IDLE;
          o_done_d = 1'b1;
          o_st_d   = ST_BAD_ADDR;
        end else begin
          phase_d  = PH_INSTR;
          o_op_d   = BUS_READ;
          o_addr_d = pa;
        end
      end else begin
        unique case (phase_q)
          PH_INSTR: begin
            il_d = in_i.read_data;
            if (last_w > {1'b0, ADDR_LIMIT}) begin
              phase_d  = PH_IDLE;
              o_done_d = 1'b1;
              o_st_d   = ST_BAD_ADDR;
            end else begin
              ox_d = ex_x;
              oy_d = ex_y;
              if (in_i.read_data[7] || in_i.read_data[3]) begin
                phase_d  = in_i.read_data[7] ? PH_X : PH_Y;
                o_op_d   = BUS_READ;
                o_addr_d = prog + 32'd1;
              end else begin
                do_exec = 1'b1;
              end
            end
          end
          PH_X: begin
            ox_d = in_i.read_data;
            if (il_q[3]) begin
              phase_d  = PH_Y;
              o_op_d   = BUS_READ;
              o_addr_d = prog + 32'd2;
            end else begin
              do_exec = 1'b1;
            end
          end
          PH_Y: begin
            oy_d    = in_i.read_data;
            do_exec = 1'b1;
          end
          PH_LOAD: begin
            phase_d = PH_IDLE;
            if (il_q[11]) begin
              ox_d = inc_x;
              if (!il_q[7]) regs_d[il_q[6:4]] = inc_x;
            end
            regs_d[il_q[10:8]] = in_i.read_data;
            pc_d     = nxt[15:0];
            pw_d     = nxt[31:16];
            o_done_d = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end

      if (do_exec) begin
        phase_d  = PH_IDLE;
        o_done_d = 1'b1;
        case (opcode_e'(ex_ins[15:12]))
          OP_WIN: begin
            if (ex_m) va_d = daddr;
            else      dw_d = ex_x[10:0];
            pc_d = nxt[15:0];
            pw_d = nxt[31:16];
          end
          OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOT, OP_XOR, OP_SHL, OP_SHR: begin
            regs_d[ex_ins[10:8]] = alu.res;
            if (alu.carry_we) carry_d = alu.carry;
            pc_d = nxt[15:0];
            pw_d = nxt[31:16];
          end
          OP_LOAD: begin
            phase_d  = PH_LOAD;
            o_done_d = 1'b0;
            o_op_d   = BUS_READ;
            o_addr_d = daddr;
          end
          OP_STORE: begin
            if (ex_m) begin
              ox_d = ex_x + 16'd1;
              if (!ex_ins[7]) regs_d[ex_ins[6:4]] = ex_x + 16'd1;
            end
            pc_d     = nxt[15:0];
            pw_d     = nxt[31:16];
            o_op_d   = BUS_WRITE;
            o_addr_d = daddr;
            o_wd_d   = ex_y;
          end
          OP_JTGT: begin
            if (ex_m) jt_d = {jt_q[31:16], ex_x};
            else      jt_d = daddr;
            pc_d = nxt[15:0];
            pw_d = nxt[31:16];
          end
          OP_JUMP: begin
            if (cc == CC_BAD0 || cc == CC_BAD1) begin
              o_st_d = ST_BAD_COND;
            end else if (cond_ok) begin
              pc_d = jt_q[15:0];
              pw_d = jt_q[31:16];
            end else begin
              pc_d = nxt[15:0];
              pw_d = nxt[31:16];
            end
          end
          OP_CALL: begin
            if (cnt_q >= STACK_CW'(STACK_DEPTH)) begin
              o_st_d = ST_OVERFLOW;
            end else begin
              push  = 1'b1;
              tos_d = nxt;
              cnt_d = cnt_q + 1'b1;
              pc_d  = ex_x;
              if (!ex_m) pw_d = {5'h0, dw_q};
            end
          end
          OP_RET: begin
            if (cnt_q == '0) begin
              o_st_d = ST_UNDERFLOW;
            end else begin
              tos_d = below;
              cnt_d = cnt_q - 1'b1;
              if (ex_m) begin
                if (!active_q) o_st_d = ST_STRAY_RET;
                masked_d = 1'b0;
                active_d = 1'b0;
                pc_d     = sr_q[15:0];
                pw_d     = sr_q[31:16] & RET_MASK[31:16];
              end else begin
                pc_d = tos_q[15:0];
                pw_d = tos_q[31:16] & RET_MASK[31:16];
              end
            end
          end
          default: begin
            o_st_d = ST_BAD_OP;
          end
        endcase
      end
    end
  end

  // Stack RAM holds entries below the top; read port primed with the next one down
  assign ram_waddr  = STACK_AW'(cnt_q - 1'b1);
  assign raddr_full = cnt_d - STACK_CW'(2);
  assign ram_raddr  = raddr_full[STACK_AW-1:0];
  assign byp_d      = push && (cnt_q != '0);
  assign byp_data_d = tos_q;

  cpu16_ram #(
    .Width (32),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (push && (cnt_q != '0)),
    .waddr_i (ram_waddr),
    .wdata_i (tos_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
      pc_q        <= '0;
      pw_q        <= '0;
      dw_q        <= '0;
      jt_q        <= '0;
      va_q        <= '0;
      sr_q        <= '0;
      masked_q    <= 1'b0;
      active_q    <= 1'b0;
      carry_q     <= 1'b0;
      cnt_q       <= '0;
      tos_q       <= '0;
      byp_q       <= 1'b0;
      byp_data_q  <= '0;
      phase_q     <= PH_IDLE;
      il_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      regs_q   <= regs_d;
      pc_q     <= pc_d;
      pw_q     <= pw_d;
      dw_q     <= dw_d;
      jt_q     <= jt_d;
      va_q     <= va_d;
      sr_q     <= sr_d;
      masked_q <= masked_d;
      active_q <= active_d;
      carry_q  <= carry_d;
      cnt_q    <= cnt_d;
      tos_q    <= tos_d;
      phase_q  <= phase_d;
      il_q     <= il_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      if (acc) begin
        byp_q       <= byp_d;
        byp_data_q  <= byp_data_d;
        out_valid_q <= 1'b1;
      end else begin
        byp_q <= 1'b0;
        if (out_o.ready) out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      o_op_q   <= o_op_d;
      o_addr_q <= o_addr_d;
      o_wd_q   <= o_wd_d;
      o_done_q <= o_done_d;
      o_st_q   <= o_st_d;
      o_pa_q   <= {pw_d, pc_d};
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.bus_op          = o_op_q;
  assign out_o.bus_address     = o_addr_q;
  assign out_o.write_data      = o_wd_q;
  assign out_o.done_res        = o_done_q;
  assign out_o.status          = o_st_q;
  assign out_o.program_address = o_pa_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= STACK_CW'(STACK_DEPTH))
    else $error("return stack count beyond depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted item produced no result");

  a_bypass_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> cnt_q >= STACK_CW'(2))
    else $error("stack bypass with fewer than two entries");

  a_load_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LOAD |-> il_q[15:12] == OP_LOAD)
    else $error("load phase without a load instruction");

  a_irq_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> masked_q)
    else $error("interrupt active while unmasked");

endmodule
